// ===== sv/atrd_pkg.sv =====
// Shared constants for the modem response terminator detector.
// Holds command codes, status codes, register indexes and character codes.
// Has no dependencies; every other file of the block uses it.
`default_nettype none

package atrd_pkg;

    localparam int unsigned BUFFER_DEPTH = 256;

    localparam int unsigned CMD_W    = 2;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned COUNT_W  = 9;
    localparam int unsigned LIMIT_W  = 9;
    localparam int unsigned TMO_W    = 16;
    localparam int unsigned TICK_W   = 17;
    localparam int unsigned POS_W    = 3;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CMD_W-1:0] CMD_START = 2'd0;
    localparam logic [CMD_W-1:0] CMD_BYTE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_RECEIVING = 3'd0;
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ERROR     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TIMEOUT   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_SILENT    = 3'd5;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 1'd1;

    localparam logic [LIMIT_W-1:0] MAX_LENGTH_RESET    = 9'd256;
    localparam logic [TMO_W-1:0]   TIMEOUT_TICKS_RESET = 16'd10000;
    localparam logic [LIMIT_W-1:0] LIMIT_MAX           = LIMIT_W'(BUFFER_DEPTH);
    localparam logic [TICK_W-1:0]  TICK_SAT            = 17'h1FFFF;

    localparam logic [BYTE_W-1:0] CH_O  = 8'h4F;
    localparam logic [BYTE_W-1:0] CH_K  = 8'h4B;
    localparam logic [BYTE_W-1:0] CH_E  = 8'h45;
    localparam logic [BYTE_W-1:0] CH_R  = 8'h52;
    localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;

    // Character expected after "E" at a given match position (one to five).
    function automatic logic [BYTE_W-1:0] error_char(input logic [POS_W-1:0] pos);
        logic [BYTE_W-1:0] ch;
        case (pos)
            3'd1:    ch = CH_R;
            3'd2:    ch = CH_R;
            3'd3:    ch = CH_O;
            3'd4:    ch = CH_R;
            3'd5:    ch = CH_CR;
            default: ch = CH_LF;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

// ===== sv/atrd_in_if.sv =====
// Input channel of the terminator detector: command and received byte.
// Depends on atrd_pkg for the field widths.
`default_nettype none

interface atrd_in_if;
    logic                           valid;
    logic                           ready;
    logic [atrd_pkg::CMD_W-1:0]     command;
    logic [atrd_pkg::BYTE_W-1:0]    rx_byte;

    modport source (output valid, output command, output rx_byte, input ready);
    modport sink (input valid, input command, input rx_byte, output ready);
endinterface

`default_nettype wire

// ===== sv/atrd_out_if.sv =====
// Result channel of the terminator detector: status, count and echoed byte.
// Depends on atrd_pkg for the field widths.
`default_nettype none

interface atrd_out_if;
    logic                           valid;
    logic                           ready;
    logic [atrd_pkg::STATUS_W-1:0]  status;
    logic [atrd_pkg::COUNT_W-1:0]   byte_count;
    logic [atrd_pkg::BYTE_W-1:0]    stored_byte;
    logic                           store_valid;

    modport source (output valid, output status, output byte_count,
                    output stored_byte, output store_valid, input ready);
    modport sink (input valid, input status, input byte_count,
                  input stored_byte, input store_valid, output ready);
endinterface

`default_nettype wire

// ===== sv/atrd_cfg_if.sv =====
// Configuration write channel of the terminator detector.
// Depends on atrd_pkg for the index and data widths.
`default_nettype none

interface atrd_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [atrd_pkg::CFG_IDX_W-1:0]     index;
    logic [atrd_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/at_response_terminator_detector.sv =====
// Modem response terminator detector, top level.
// Depends on atrd_pkg, atrd_in_if, atrd_out_if and atrd_cfg_if.
//
// The in channel carries one command per transfer: start a new response,
// a received byte, or a one millisecond tick. Every accepted transfer
// produces exactly one transfer on the out channel with the status and
// byte count after that command, and the byte echoed with store_valid set
// when it was taken into the response, for storage at byte_count minus one.
// A response ends on a line reading OK or ERROR followed by CR LF after a
// newline, when the byte count reaches max_length (0 acts as 1, at most
// 256), or when the tick count exceeds timeout_ticks; later bytes and
// ticks are ignored. One result register sets the timing: the result
// appears in the cycle after acceptance, and one item is taken in every
// cycle while results are taken. When the receiver stalls, the result
// register holds and the in channel drops ready until it is taken.
// Reset clears the response as if a start command had been given and loads
// the register defaults. The cfg channel is always ready; write it only
// while no results are pending.
`default_nettype none

module at_response_terminator_detector (
    input  wire logic       clk,
    input  wire logic       rst_n,
    atrd_in_if.sink         req,
    atrd_out_if.source      rsp,
    atrd_cfg_if.sink        cfg
);

    typedef enum logic [1:0] {
        PS_TEXT,
        PS_NEWLINE,
        PS_OK,
        PS_ERROR
    } parse_state_t;

    logic [atrd_pkg::LIMIT_W-1:0]   max_length_reg;
    logic [atrd_pkg::TMO_W-1:0]     timeout_reg;

    parse_state_t                   parse_reg, parse_next;
    logic [atrd_pkg::POS_W-1:0]     pos_reg, pos_next;
    logic [atrd_pkg::COUNT_W-1:0]   count_reg, count_next;
    logic [atrd_pkg::TICK_W-1:0]    ticks_reg, ticks_next;
    logic [atrd_pkg::STATUS_W-1:0]  status_reg, status_next;
    logic [atrd_pkg::BYTE_W-1:0]    stored_reg, stored_next;
    logic                           store_valid_reg, store_valid_next;
    logic                           out_valid_reg;

    logic                           accept;
    logic [atrd_pkg::LIMIT_W-1:0]   limit;
    logic [atrd_pkg::BYTE_W-1:0]    ch;
    logic                           end_ok;
    logic                           end_error;

    assign accept    = req.valid && req.ready;
    assign req.ready = !out_valid_reg || rsp.ready;
    assign cfg.ready = 1'b1;

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.byte_count  = count_reg;
    assign rsp.stored_byte = stored_reg;
    assign rsp.store_valid = store_valid_reg;

    assign ch = req.rx_byte;

    always_comb
    begin
        if (max_length_reg == '0)
        begin
            limit = atrd_pkg::LIMIT_W'(1);
        end
        else if (max_length_reg > atrd_pkg::LIMIT_MAX)
        begin
            limit = atrd_pkg::LIMIT_MAX;
        end
        else
        begin
            limit = max_length_reg;
        end
    end

    // Parser step for one received byte.
    always_comb
    begin
        parse_next = parse_reg;
        pos_next   = pos_reg;
        end_ok     = 1'b0;
        end_error  = 1'b0;
        case (parse_reg)
            PS_TEXT:
            begin
                if (ch == atrd_pkg::CH_LF)
                begin
                    parse_next = PS_NEWLINE;
                end
            end
            PS_NEWLINE:
            begin
                if (ch == atrd_pkg::CH_O)
                begin
                    parse_next = PS_OK;
                    pos_next   = 3'd1;
                end
                else if (ch == atrd_pkg::CH_E)
                begin
                    parse_next = PS_ERROR;
                    pos_next   = 3'd1;
                end
                else
                begin
                    parse_next = PS_TEXT;
                end
            end
            PS_OK:
            begin
                if ((ch == atrd_pkg::CH_K && pos_reg == 3'd1) ||
                    (ch == atrd_pkg::CH_CR && pos_reg == 3'd2))
                begin
                    pos_next = pos_reg + 3'd1;
                end
                else if (ch == atrd_pkg::CH_LF && pos_reg == 3'd3)
                begin
                    end_ok = 1'b1;
                end
                else
                begin
                    parse_next = PS_TEXT;
                end
            end
            default:
            begin
                if (pos_reg >= 3'd1 && pos_reg <= 3'd5 &&
                    ch == atrd_pkg::error_char(pos_reg))
                begin
                    pos_next = pos_reg + 3'd1;
                end
                else if (pos_reg == 3'd6 && ch == atrd_pkg::CH_LF)
                begin
                    end_error = 1'b1;
                end
                else
                begin
                    parse_next = PS_TEXT;
                end
            end
        endcase
    end

    always_comb
    begin
        status_next      = status_reg;
        count_next       = count_reg;
        ticks_next       = ticks_reg;
        stored_next      = '0;
        store_valid_next = 1'b0;
        case (req.command)
            atrd_pkg::CMD_START:
            begin
                status_next = atrd_pkg::ST_RECEIVING;
                count_next  = '0;
                ticks_next  = '0;
            end
            atrd_pkg::CMD_BYTE:
            begin
                if (status_reg == atrd_pkg::ST_RECEIVING)
                begin
                    stored_next      = ch;
                    store_valid_next = 1'b1;
                    count_next       = count_reg + atrd_pkg::COUNT_W'(1);
                    if (end_ok)
                    begin
                        status_next = atrd_pkg::ST_OK;
                    end
                    else if (end_error)
                    begin
                        status_next = atrd_pkg::ST_ERROR;
                    end
                    else if (count_next >= limit)
                    begin
                        status_next = atrd_pkg::ST_FULL;
                    end
                end
            end
            atrd_pkg::CMD_TICK:
            begin
                if (status_reg == atrd_pkg::ST_RECEIVING)
                begin
                    if (ticks_reg != atrd_pkg::TICK_SAT)
                    begin
                        ticks_next = ticks_reg + atrd_pkg::TICK_W'(1);
                    end
                    if (ticks_next > {1'b0, timeout_reg})
                    begin
                        status_next = (count_reg != '0) ? atrd_pkg::ST_TIMEOUT
                                                         : atrd_pkg::ST_SILENT;
                    end
                end
            end
            default:
            begin
                status_next = status_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_length_reg <= atrd_pkg::MAX_LENGTH_RESET;
            timeout_reg    <= atrd_pkg::TIMEOUT_TICKS_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                atrd_pkg::REG_MAX_LENGTH:
                begin
                    max_length_reg <= cfg.data[atrd_pkg::LIMIT_W-1:0];
                end
                atrd_pkg::REG_TIMEOUT_TICKS:
                begin
                    timeout_reg <= cfg.data[atrd_pkg::TMO_W-1:0];
                end
                default:
                begin
                    timeout_reg <= timeout_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parse_reg       <= PS_TEXT;
            pos_reg         <= '0;
            count_reg       <= '0;
            ticks_reg       <= '0;
            status_reg      <= atrd_pkg::ST_RECEIVING;
            stored_reg      <= '0;
            store_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                out_valid_reg   <= 1'b1;
                count_reg       <= count_next;
                ticks_reg       <= ticks_next;
                status_reg      <= status_next;
                stored_reg      <= stored_next;
                store_valid_reg <= store_valid_next;
                if (req.command == atrd_pkg::CMD_START)
                begin
                    parse_reg <= PS_TEXT;
                    pos_reg   <= '0;
                end
                else if (req.command == atrd_pkg::CMD_BYTE &&
                         status_reg == atrd_pkg::ST_RECEIVING)
                begin
                    parse_reg <= parse_next;
                    pos_reg   <= pos_next;
                end
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== sim/tb_at_response_terminator_detector.sv =====
// Self-checking testbench for the modem response terminator detector.
// Drives commands, bytes and ticks, predicts every result and compares it.
// Depends on atrd_pkg, the three channel interfaces and the detector top level.

module tb_at_response_terminator_detector;

    localparam logic [atrd_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int LONG_HOLD       = 300;
    localparam int PHASE_ITEMS     = 70;
    localparam int WATCHDOG_CYCLES = 500000;

    typedef enum logic [1:0] {PARSE_TEXT, PARSE_NEWLINE, PARSE_OK, PARSE_ERROR} parse_t;

    typedef struct packed {
        logic [atrd_pkg::CMD_W-1:0]  command;
        logic [atrd_pkg::BYTE_W-1:0] rx_byte;
    } cmd_item_t;

    typedef struct packed {
        logic [atrd_pkg::STATUS_W-1:0] status;
        logic [atrd_pkg::COUNT_W-1:0]  byte_count;
        logic [atrd_pkg::BYTE_W-1:0]   stored_byte;
        logic                          store_valid;
    } rsp_item_t;

    logic clk;
    logic rst_n;

    atrd_in_if  req_if ();
    atrd_out_if rsp_if ();
    atrd_cfg_if cfg_if ();

    at_response_terminator_detector uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if),
        .cfg   (cfg_if)
    );

    cmd_item_t pending_items [$];
    rsp_item_t expected_results [$];

    int items_queued    = 0;
    int items_accepted  = 0;
    int results_checked = 0;
    int errors          = 0;
    int body_items      = 0;
    int responses_sent  = 0;
    int settings_used   = 0;
    int holds_asked     = 0;
    int holds_done      = 0;
    int gap_left        = 0;
    int stall_left      = 0;
    int hold_left       = 0;
    int gap_pct         = 25;
    int stall_pct       = 25;
    int tick_pct        = 0;
    int cur_timeout     = 10000;
    bit quiet_tail      = 1'b0;
    int status_seen [0:7];

    logic [atrd_pkg::LIMIT_W-1:0]  cfg_max_length;
    logic [atrd_pkg::TMO_W-1:0]    cfg_timeout;
    parse_t                        resp_parse;
    logic [atrd_pkg::POS_W-1:0]    resp_pos;
    logic [atrd_pkg::COUNT_W-1:0]  resp_count;
    logic [atrd_pkg::TICK_W-1:0]   resp_ticks;
    logic [atrd_pkg::STATUS_W-1:0] resp_status;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #(4 * WATCHDOG_CYCLES);
        $display("%0t: run did not finish in time", $time);
        $display("TEST FAILED");
        $finish;
    end

    function automatic void clear_response();
        resp_parse  = PARSE_TEXT;
        resp_pos    = '0;
        resp_count  = '0;
        resp_ticks  = '0;
        resp_status = atrd_pkg::ST_RECEIVING;
    endfunction

    function automatic rsp_item_t detect_step(input cmd_item_t it);
        rsp_item_t                     r;
        logic [atrd_pkg::STATUS_W-1:0] fin;
        logic [atrd_pkg::BYTE_W-1:0]   want;
        logic [atrd_pkg::LIMIT_W-1:0]  lim;
        r.stored_byte = '0;
        r.store_valid = 1'b0;
        fin = atrd_pkg::ST_RECEIVING;
        lim = (cfg_max_length == '0) ? atrd_pkg::LIMIT_W'(1) : cfg_max_length;
        if (lim > atrd_pkg::LIMIT_MAX)
            lim = atrd_pkg::LIMIT_MAX;
        case (it.command)
            atrd_pkg::CMD_START:
                clear_response();
            atrd_pkg::CMD_BYTE:
                if (resp_status == atrd_pkg::ST_RECEIVING)
                begin
                    case (resp_parse)
                        PARSE_TEXT:
                            if (it.rx_byte == atrd_pkg::CH_LF)
                                resp_parse = PARSE_NEWLINE;
                        PARSE_NEWLINE:
                            if (it.rx_byte == atrd_pkg::CH_O)
                            begin
                                resp_parse = PARSE_OK;
                                resp_pos = 3'd1;
                            end
                            else if (it.rx_byte == atrd_pkg::CH_E)
                            begin
                                resp_parse = PARSE_ERROR;
                                resp_pos = 3'd1;
                            end
                            else
                                resp_parse = PARSE_TEXT;
                        PARSE_OK:
                            if ((it.rx_byte == atrd_pkg::CH_K && resp_pos == 3'd1) ||
                                (it.rx_byte == atrd_pkg::CH_CR && resp_pos == 3'd2))
                                resp_pos = resp_pos + 3'd1;
                            else if (it.rx_byte == atrd_pkg::CH_LF && resp_pos == 3'd3)
                                fin = atrd_pkg::ST_OK;
                            else
                                resp_parse = PARSE_TEXT;
                        default:
                        begin
                            case (resp_pos)
                                3'd3:    want = atrd_pkg::CH_O;
                                3'd5:    want = atrd_pkg::CH_CR;
                                default: want = atrd_pkg::CH_R;
                            endcase
                            if (resp_pos >= 3'd1 && resp_pos <= 3'd5 && it.rx_byte == want)
                                resp_pos = resp_pos + 3'd1;
                            else if (resp_pos == 3'd6 && it.rx_byte == atrd_pkg::CH_LF)
                                fin = atrd_pkg::ST_ERROR;
                            else
                                resp_parse = PARSE_TEXT;
                        end
                    endcase
                    r.stored_byte = it.rx_byte;
                    r.store_valid = 1'b1;
                    resp_count = resp_count + atrd_pkg::COUNT_W'(1);
                    if (fin != atrd_pkg::ST_RECEIVING)
                        resp_status = fin;
                    else if (resp_count >= lim)
                        resp_status = atrd_pkg::ST_FULL;
                end
            atrd_pkg::CMD_TICK:
                if (resp_status == atrd_pkg::ST_RECEIVING)
                begin
                    if (resp_ticks < atrd_pkg::TICK_SAT)
                        resp_ticks = resp_ticks + atrd_pkg::TICK_W'(1);
                    if (resp_ticks > {1'b0, cfg_timeout})
                        resp_status = (resp_count != '0) ? atrd_pkg::ST_TIMEOUT
                                                         : atrd_pkg::ST_SILENT;
                end
            default:
                ;
        endcase
        r.status = resp_status;
        r.byte_count = resp_count;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : driver_proc
        cmd_item_t nxt;
        if (!rst_n)
        begin
            req_if.valid   <= 1'b0;
            req_if.command <= atrd_pkg::CMD_START;
            req_if.rx_byte <= '0;
            gap_left = 0;
        end
        else if (!req_if.valid || req_if.ready)
        begin
            if (req_if.valid && !quiet_tail && $urandom_range(99) < gap_pct)
                gap_left = $urandom_range(1, 10);
            if (gap_left > 0)
            begin
                gap_left = gap_left - 1;
                req_if.valid <= 1'b0;
            end
            else if (pending_items.size() > 0)
            begin
                nxt = pending_items.pop_front();
                req_if.valid   <= 1'b1;
                req_if.command <= nxt.command;
                req_if.rx_byte <= nxt.rx_byte;
            end
            else
                req_if.valid <= 1'b0;
        end
    end

    // The long hold-off is counted here so that the sender keeps offering meanwhile.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_if.ready <= 1'b0;
            stall_left = 0;
            hold_left = 0;
        end
        else
        begin
            if (holds_done < holds_asked && hold_left == 0)
            begin
                hold_left = LONG_HOLD;
                holds_done = holds_done + 1;
            end
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                rsp_if.ready <= 1'b0;
            end
            else
            begin
                if (stall_left == 0 && !quiet_tail && $urandom_range(99) < stall_pct)
                    stall_left = $urandom_range(1, 10);
                if (stall_left > 0)
                begin
                    stall_left = stall_left - 1;
                    rsp_if.ready <= 1'b0;
                end
                else
                    rsp_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : monitor_proc
        cmd_item_t taken;
        rsp_item_t want;
        if (!rst_n)
        begin
            cfg_max_length = atrd_pkg::MAX_LENGTH_RESET;
            cfg_timeout = atrd_pkg::TIMEOUT_TICKS_RESET;
            clear_response();
        end
        else
        begin
            if (cfg_if.valid && cfg_if.ready)
            begin
                if (cfg_if.index == atrd_pkg::REG_MAX_LENGTH)
                    cfg_max_length = cfg_if.data[atrd_pkg::LIMIT_W-1:0];
                else if (cfg_if.index == atrd_pkg::REG_TIMEOUT_TICKS)
                    cfg_timeout = cfg_if.data;
            end
            if (req_if.valid && req_if.ready)
            begin
                taken.command = req_if.command;
                taken.rx_byte = req_if.rx_byte;
                expected_results.push_back(detect_step(taken));
                items_accepted = items_accepted + 1;
            end
            if (rsp_if.valid && rsp_if.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result, status %0d count %0d", $time,
                             rsp_if.status, rsp_if.byte_count);
                    errors = errors + 1;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (rsp_if.status !== want.status)
                    begin
                        $display("%0t: status expected %0d, actual %0d", $time,
                                 want.status, rsp_if.status);
                        errors = errors + 1;
                    end
                    if (rsp_if.byte_count !== want.byte_count)
                    begin
                        $display("%0t: byte_count expected %0d, actual %0d", $time,
                                 want.byte_count, rsp_if.byte_count);
                        errors = errors + 1;
                    end
                    if (rsp_if.stored_byte !== want.stored_byte)
                    begin
                        $display("%0t: stored_byte expected %h, actual %h", $time,
                                 want.stored_byte, rsp_if.stored_byte);
                        errors = errors + 1;
                    end
                    if (rsp_if.store_valid !== want.store_valid)
                    begin
                        $display("%0t: store_valid expected %b, actual %b", $time,
                                 want.store_valid, rsp_if.store_valid);
                        errors = errors + 1;
                    end
                    status_seen[want.status] = status_seen[want.status] + 1;
                    results_checked = results_checked + 1;
                end
            end
        end
    end

    task automatic queue_item(input logic [atrd_pkg::CMD_W-1:0] cmd,
                              input logic [atrd_pkg::BYTE_W-1:0] b);
        cmd_item_t it;
        it.command = cmd;
        it.rx_byte = b;
        pending_items.push_back(it);
        items_queued = items_queued + 1;
        body_items = body_items + 1;
    endtask

    task automatic queue_byte(input logic [atrd_pkg::BYTE_W-1:0] b);
        if (tick_pct != 0 && $urandom_range(99) < tick_pct)
            queue_item(atrd_pkg::CMD_TICK, atrd_pkg::BYTE_W'($urandom));
        queue_item(atrd_pkg::CMD_BYTE, b);
    endtask

    task automatic queue_ticks(input int n);
        repeat (n)
            queue_item(atrd_pkg::CMD_TICK, atrd_pkg::BYTE_W'($urandom));
    endtask

    task automatic queue_text(input int n);
        repeat (n)
            queue_byte(atrd_pkg::BYTE_W'($urandom));
    endtask

    // Line break followed by OK or ERROR and its CR LF, cut after keep bytes.
    task automatic queue_final(input bit is_error, input int keep);
        logic [atrd_pkg::BYTE_W-1:0] seq [0:8];
        int n;
        int i;
        seq[0] = atrd_pkg::CH_CR;
        seq[1] = atrd_pkg::CH_LF;
        if (is_error)
        begin
            seq[2] = atrd_pkg::CH_E;
            seq[3] = atrd_pkg::CH_R;
            seq[4] = atrd_pkg::CH_R;
            seq[5] = atrd_pkg::CH_O;
            seq[6] = atrd_pkg::CH_R;
            seq[7] = atrd_pkg::CH_CR;
            seq[8] = atrd_pkg::CH_LF;
            n = 9;
        end
        else
        begin
            seq[2] = atrd_pkg::CH_O;
            seq[3] = atrd_pkg::CH_K;
            seq[4] = atrd_pkg::CH_CR;
            seq[5] = atrd_pkg::CH_LF;
            n = 6;
        end
        if (keep < n)
            n = keep;
        for (i = 0; i < n; i++)
            queue_byte(seq[i]);
    endtask

    task automatic queue_trailer();
        int saved;
        saved = body_items;
        repeat ($urandom_range(0, 3))
            queue_item(atrd_pkg::CMD_W'($urandom_range(1, 3)), atrd_pkg::BYTE_W'($urandom));
        body_items = saved;
    endtask

    task automatic gen_response();
        int kind;
        int full;
        bit err;
        kind = $urandom_range(99);
        err = 1'($urandom_range(1));
        full = err ? 9 : 6;
        responses_sent = responses_sent + 1;
        queue_item(atrd_pkg::CMD_START, atrd_pkg::BYTE_W'($urandom));
        if (kind >= 95)
        begin
            repeat ($urandom_range(5, 20))
                queue_item(atrd_pkg::CMD_W'($urandom_range(0, 3)),
                           atrd_pkg::BYTE_W'($urandom));
            return;
        end
        queue_text($urandom_range(0, 10));
        repeat ($urandom_range(0, 3))
        begin
            queue_byte(atrd_pkg::CH_CR);
            queue_byte(atrd_pkg::CH_LF);
            queue_text($urandom_range(0, 10));
        end
        if (kind < 65)
            queue_final(err, full);
        else if (kind < 80)
        begin
            queue_final(err, $urandom_range(2, full - 1));
            queue_byte(atrd_pkg::BYTE_W'($urandom));
            if ($urandom_range(1))
                queue_final(!err, 9);
        end
        else if (kind < 88)
        begin
            if (cur_timeout <= 60)
                queue_ticks(cur_timeout + 1);
        end
        else if (kind < 95)
        begin
            if (cur_timeout <= 60)
            begin
                pending_items.pop_back();
                items_queued = items_queued - 1;
                queue_item(atrd_pkg::CMD_START, atrd_pkg::BYTE_W'($urandom));
                queue_ticks(cur_timeout + 1);
            end
        end
        queue_trailer();
    endtask

    task automatic wait_drained();
        while (items_accepted != items_queued || expected_results.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input logic [atrd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [atrd_pkg::CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    initial
    begin : stimulus
        logic [atrd_pkg::CFG_DATA_W-1:0] len_set [0:9];
        logic [atrd_pkg::CFG_DATA_W-1:0] tmo_set [0:9];
        int p;
        int target;
        len_set = '{16'hFE00, 16'd1, 16'd511, 16'd257, 16'd6,
                    16'd40, 16'd256, 16'd300, 16'd64, 16'd128};
        tmo_set = '{16'd1, 16'd65535, 16'd3, 16'd20, 16'd8,
                    16'd50, 16'd2, 16'd12, 16'd30, 16'd400};
        rst_n <= 1'b0;
        cfg_if.valid <= 1'b0;
        cfg_if.index <= atrd_pkg::REG_MAX_LENGTH;
        cfg_if.data  <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Register defaults: plain endings, broken lines, ignored items after the end.
        queue_item(atrd_pkg::CMD_START, 8'h00);
        queue_final(1'b0, 9);
        queue_item(atrd_pkg::CMD_BYTE, 8'hFF);
        queue_item(atrd_pkg::CMD_TICK, 8'h00);
        queue_item(CMD_UNUSED, 8'hFF);
        queue_item(atrd_pkg::CMD_START, 8'hFF);
        queue_final(1'b1, 9);
        queue_item(atrd_pkg::CMD_START, 8'h00);
        queue_byte(atrd_pkg::CH_O);
        queue_byte(atrd_pkg::CH_K);
        queue_byte(atrd_pkg::CH_CR);
        queue_byte(atrd_pkg::CH_LF);
        queue_byte(atrd_pkg::CH_LF);
        queue_byte(atrd_pkg::CH_O);
        queue_byte(atrd_pkg::CH_K);
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_item(CMD_UNUSED, 8'h00);
        queue_final(1'b1, 6);
        queue_byte(atrd_pkg::CH_CR);
        queue_final(1'b0, 9);

        queue_item(atrd_pkg::CMD_START, atrd_pkg::BYTE_W'($urandom));
        queue_text(256);
        queue_item(atrd_pkg::CMD_BYTE, atrd_pkg::BYTE_W'($urandom));
        queue_item(atrd_pkg::CMD_START, atrd_pkg::BYTE_W'($urandom));
        queue_ticks(20);
        wait_drained();

        // A terminator that also reaches the length limit wins over the full status.
        quiet_tail = 1'b0;
        write_reg(atrd_pkg::REG_MAX_LENGTH, 16'd9);
        settings_used = settings_used + 1;
        queue_item(atrd_pkg::CMD_START, atrd_pkg::BYTE_W'($urandom));
        queue_text(3);
        queue_final(1'b0, 9);
        queue_item(atrd_pkg::CMD_START, atrd_pkg::BYTE_W'($urandom));
        queue_final(1'b1, 9);
        queue_item(atrd_pkg::CMD_BYTE, atrd_pkg::BYTE_W'($urandom));
        wait_drained();

        for (p = 0; p < 10; p++)
        begin
            write_reg(atrd_pkg::REG_MAX_LENGTH, len_set[p]);
            write_reg(atrd_pkg::REG_TIMEOUT_TICKS, tmo_set[p]);
            cur_timeout = int'(tmo_set[p]);
            settings_used = settings_used + 1;
            gap_pct = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 20 : 50);
            stall_pct = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 20 : 40);
            tick_pct = 5 + (p % 3) * 5;
            quiet_tail = (p == 9);
            target = body_items + PHASE_ITEMS;
            if (p == 3)
            begin
                while (body_items < target)
                    gen_response();
                holds_asked = holds_asked + 1;
            end
            else if (p == 5)
            begin
                while (body_items < target - PHASE_ITEMS / 2)
                    gen_response();
                wait_drained();
                while (body_items < target)
                    gen_response();
            end
            else
            begin
                while (body_items < target)
                    gen_response();
            end
            wait_drained();
        end

        repeat (20) @(posedge clk);
        $display("Summary: %0d transfers in, %0d results checked, %0d responses, %0d settings",
                 items_accepted, results_checked, responses_sent, settings_used);
        $display("Summary: receiving %0d, ok %0d, error %0d, full %0d, timeout %0d, silent %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4], status_seen[5]);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
